// ===== rtl/core/csr_pkg.sv =====
// ----------------------------------------------------------------------------
// csr_pkg
// Shared types and constants for the circle versus wall collision resolver.
// ----------------------------------------------------------------------------
package csr_pkg;

    localparam int WALL_DEPTH_DEF = 64;
    localparam int FRAC_BITS_DEF  = 12;

    localparam logic [11:0] RADIUS_RST = 12'd1229;
    localparam logic [3:0]  PASSES_RST = 4'd4;

    // register indexes on the configuration port (byte address / 4)
    typedef enum logic [1:0] {
        REG_ACTIVE = 2'd0,
        REG_RADIUS = 2'd1,
        REG_PASSES = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2,
        OP_NOP  = 2'd3
    } t_arith_op;

    typedef struct packed {
        logic      start;
        t_arith_op op;
        logic [4:0] steps;
    } t_arith_req;

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        logic signed [23:0] r;
        if (v > 64'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -64'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/csr_arith.sv =====
// ----------------------------------------------------------------------------
// csr_arith
// Shared multi-cycle arithmetic unit: signed multiply (16-bit digit per
// cycle), restoring divide (one quotient bit per cycle) and integer square
// root (one result bit per cycle).
// ----------------------------------------------------------------------------
module csr_arith
    import csr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_arith_req  i_req,
    input  logic [63:0] i_op_a,   // mul: a, div: starting remainder, sqrt: value
    input  logic [63:0] i_op_b,   // mul: b, div: dividend bits shifted in from bit 23
    input  logic [63:0] i_op_c,   // div: divisor
    output logic        o_done,
    output logic [63:0] o_res
);

    logic        r_busy;
    logic        r_fin;
    t_arith_op   r_op;
    logic [4:0]  r_cnt;
    logic        r_neg;
    logic [63:0] r_x;
    logic [63:0] r_y;
    logic [63:0] r_acc;
    logic [63:0] r_den;

    logic [63:0] w_mag_a;
    logic [63:0] w_mag_b;
    logic [63:0] w_prod;
    logic [63:0] w_dshift;
    logic        w_dge;
    logic [63:0] w_strial;

    always_comb begin
        w_mag_a  = i_op_a[63] ? (~i_op_a + 64'd1) : i_op_a;
        w_mag_b  = i_op_b[63] ? (~i_op_b + 64'd1) : i_op_b;
        w_prod   = r_x[47:0] * r_y[15:0];
        w_dshift = {r_acc[62:0], r_y[23]};
        w_dge    = (w_dshift >= r_den);
        w_strial = r_acc + r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_op   <= OP_NOP;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                unique case (i_req.op)
                    OP_MUL: begin
                        r_cnt <= 5'd1;
                        r_neg <= i_op_a[63] ^ i_op_b[63];
                        r_x   <= {32'd0, w_mag_a[31:0]};
                        r_y   <= {32'd0, w_mag_b[31:0]};
                        r_acc <= '0;
                    end
                    OP_DIV: begin
                        r_cnt <= i_req.steps - 5'd1;
                        r_acc <= i_op_a;
                        r_y   <= i_op_b;
                        r_den <= i_op_c;
                        r_x   <= '0;
                    end
                    OP_SQRT: begin
                        r_cnt <= 5'd31;
                        r_x   <= i_op_a;
                        r_y   <= 64'h4000_0000_0000_0000;
                        r_acc <= '0;
                    end
                    default: begin
                        r_cnt <= '0;
                    end
                endcase
            end else if (r_busy) begin
                unique case (r_op)
                    OP_MUL: begin
                        r_acc <= r_acc + w_prod;
                        r_x   <= r_x << 16;
                        r_y   <= r_y >> 16;
                    end
                    OP_DIV: begin
                        r_acc <= w_dge ? (w_dshift - r_den) : w_dshift;
                        r_x   <= {r_x[62:0], w_dge};
                        r_y   <= r_y << 1;
                    end
                    OP_SQRT: begin
                        if (r_x >= w_strial) begin
                            r_x   <= r_x - w_strial;
                            r_acc <= (r_acc >> 1) + r_y;
                        end else begin
                            r_acc <= r_acc >> 1;
                        end
                        r_y <= r_y >> 2;
                    end
                    default: ;
                endcase
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        unique case (r_op)
            OP_MUL:  o_res = r_neg ? (~r_acc + 64'd1) : r_acc;
            OP_DIV:  o_res = r_x;
            OP_SQRT: o_res = r_acc;
            default: o_res = '0;
        endcase
    end

    assign o_done = r_fin;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (!r_busy && !r_fin))
        else $error("arith start while busy");
    a_fin_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> $past(r_busy))
        else $error("arith done without work");
    a_mul_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_op == OP_MUL)) |-> (r_cnt <= 5'd1))
        else $error("multiply step count out of range");

endmodule

// ===== rtl/core/circle_segment_collision_resolver_top.sv =====
// ----------------------------------------------------------------------------
// circle_segment_collision_resolver_top
// Pushes a circle out of a table of wall segments, Q12.12 fixed point.
// ----------------------------------------------------------------------------
// A load request (tuser = 0) writes one wall into a single-port table and
// returns an all-zero result by way of S_DONE. A resolve request (tuser = 1)
// walks the first active_walls entries for up to max_passes passes, one
// wall at a time through one shared multi-cycle arithmetic unit. Requests
// are handled one at a time; the next request is taken while the previous
// result waits on the output.
// ----------------------------------------------------------------------------
module circle_segment_collision_resolver_top
    import csr_pkg::*;
#(
    parameter int WALL_DEPTH = WALL_DEPTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // wall_slot, start_x, start_z, end_x, end_z, pos_x, pos_z, vel_x, vel_z, pad
    input  logic [199:0] s_axis_tdata,
    // func
    input  logic         s_axis_tuser,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_pos_x, out_pos_z, out_vel_x, out_vel_z, any_contact, pad
    output logic [103:0] m_axis_tdata
);

    localparam int AW = (WALL_DEPTH > 1) ? $clog2(WALL_DEPTH) : 1;
    localparam int CW = $clog2(WALL_DEPTH + 1);
    localparam logic [63:0] EPS2_Q = (64'd1 << (2 * FRAC_BITS)) / 64'd100000000;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_LD, S_LEN_X, S_LEN_Z, S_DOT_X, S_DOT_Z, S_T_DIV,
        S_CL_X, S_CL_Z, S_D2_X, S_D2_Z, S_DH, S_LH, S_NX, S_NZ,
        S_PUSH_X, S_PUSH_Z, S_S_X, S_S_Z, S_V_X, S_V_Z, S_WEND, S_DONE
    } t_state;

    // configuration
    logic [6:0]  r_active;
    logic [11:0] r_radius;
    logic [3:0]  r_passes;

    // sequencer
    t_state      r_state;
    logic        r_issued;
    logic [CW-1:0] r_widx;
    logic [3:0]  r_pass;
    logic        r_pass_hit;
    logic        r_any;
    logic        r_perp;

    // wall table
    logic [95:0] r_mem [WALL_DEPTH];
    logic [95:0] r_rd;

    // working values
    logic signed [23:0] r_px, r_pz, r_vx, r_vz;
    logic signed [24:0] r_wx, r_wz, r_prx, r_prz;
    logic [50:0]        r_len2;
    logic signed [63:0] r_dot;
    logic [24:0]        r_t;
    logic signed [26:0] r_dx, r_dz;
    logic [63:0]        r_d2;
    logic [19:0]        r_dh;
    logic [30:0]        r_lh;
    logic signed [19:0] r_nx, r_nz;
    logic signed [63:0] r_s;

    // output register
    logic        r_out_valid;
    logic [96:0] r_out;

    // arithmetic unit
    t_arith_req  w_req;
    logic [63:0] w_op_a, w_op_b, w_op_c;
    logic        w_done;
    logic [63:0] w_res;
    logic signed [63:0] w_sres;

    logic [CW-1:0] w_nwalls;
    logic          w_in_acc;
    logic          w_wr;
    logic [23:0]   w_in_px, w_in_pz, w_in_vx, w_in_vz;
    logic signed [63:0] w_num_src, w_num, w_pen, w_vin, w_rnd24, w_rnd16;
    logic [63:0]   w_num_mag, w_den, w_dvd;
    logic [23:0]   w_r2;
    logic [63:0]   w_sum;
    logic signed [63:0] w_ssum;
    logic [AW-1:0] w_slot;
    logic signed [23:0] w_x1, w_z1, w_x2, w_z2;
    logic signed [63:0] w_cx, w_cz;

    csr_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_op_a  (w_op_a),
        .i_op_b  (w_op_b),
        .i_op_c  (w_op_c),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_radius <= RADIUS_RST;
            r_passes <= PASSES_RST;
        end else if (w_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_ACTIVE: r_active <= pwdata[6:0];
                REG_RADIUS: r_radius <= pwdata[11:0];
                REG_PASSES: r_passes <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_ACTIVE: prdata = {25'd0, r_active};
            REG_RADIUS: prdata = {20'd0, r_radius};
            REG_PASSES: prdata = {28'd0, r_passes};
            default:    prdata = '0;
        endcase
    end

    // ---------------- datapath helpers ----------------
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_slot        = AW'(s_axis_tdata[5:0]);
    assign w_in_px       = s_axis_tdata[125:102];
    assign w_in_pz       = s_axis_tdata[149:126];
    assign w_in_vx       = s_axis_tdata[173:150];
    assign w_in_vz       = s_axis_tdata[197:174];

    assign w_x1 = r_rd[23:0];
    assign w_z1 = r_rd[47:24];
    assign w_x2 = r_rd[71:48];
    assign w_z2 = r_rd[95:72];

    assign w_nwalls = (32'(r_active) > WALL_DEPTH) ? CW'(WALL_DEPTH) : CW'(r_active);
    assign w_sres   = signed'(w_res);
    assign w_r2     = r_radius * r_radius;
    assign w_rnd24  = (w_sres + 64'sd8388608) >>> 24;
    assign w_rnd16  = (w_sres + 64'sd32768) >>> 16;
    assign w_vin    = (r_s + 64'sd32768) >>> 16;
    assign w_pen    = 64'(signed'({1'b0, r_radius, 8'd0})) - 64'(signed'({1'b0, r_dh}));
    assign w_cx     = 64'(w_x1) + w_rnd24;
    assign w_cz     = 64'(w_z1) + w_rnd24;

    always_comb begin
        if (r_perp) begin
            w_num_src = (r_state == S_NX) ? -64'(r_wz) : 64'(r_wz);
            if (r_state != S_NX) begin
                w_num_src = 64'(r_wx);
            end
            w_num = w_num_src <<< 22;
            w_den = {33'd0, r_lh};
        end else begin
            w_num_src = (r_state == S_NX) ? 64'(r_dx) : 64'(r_dz);
            w_num = w_num_src <<< 24;
            w_den = {44'd0, r_dh};
        end
        w_num_mag = w_num[63] ? unsigned'(-w_num) : unsigned'(w_num);
        w_dvd     = w_num_mag + (w_den >> 1);
    end

    // arithmetic requests
    always_comb begin
        w_req.start = 1'b0;
        w_req.op    = OP_NOP;
        w_req.steps = 5'd0;
        w_op_a      = '0;
        w_op_b      = '0;
        w_op_c      = '0;
        unique case (r_state)
            S_LEN_X:  begin w_req.op = OP_MUL; w_op_a = 64'(r_wx);  w_op_b = 64'(r_wx); end
            S_LEN_Z:  begin w_req.op = OP_MUL; w_op_a = 64'(r_wz);  w_op_b = 64'(r_wz); end
            S_DOT_X:  begin w_req.op = OP_MUL; w_op_a = 64'(r_prx); w_op_b = 64'(r_wx); end
            S_DOT_Z:  begin w_req.op = OP_MUL; w_op_a = 64'(r_prz); w_op_b = 64'(r_wz); end
            S_T_DIV: begin
                w_req.op    = OP_DIV;
                w_req.steps = 5'd24;
                w_op_a      = r_dot;
                w_op_c      = {13'd0, r_len2};
            end
            S_CL_X:   begin w_req.op = OP_MUL; w_op_a = 64'(r_wx); w_op_b = {39'd0, r_t}; end
            S_CL_Z:   begin w_req.op = OP_MUL; w_op_a = 64'(r_wz); w_op_b = {39'd0, r_t}; end
            S_D2_X:   begin w_req.op = OP_MUL; w_op_a = 64'(r_dx); w_op_b = 64'(r_dx); end
            S_D2_Z:   begin w_req.op = OP_MUL; w_op_a = 64'(r_dz); w_op_b = 64'(r_dz); end
            S_DH:     begin w_req.op = OP_SQRT; w_op_a = r_d2 << 16; end
            S_LH:     begin w_req.op = OP_SQRT; w_op_a = {1'b0, r_len2, 12'd0}; end
            S_NX, S_NZ: begin
                w_req.op    = OP_DIV;
                w_req.steps = 5'd20;
                w_op_a      = w_dvd >> 20;
                w_op_b      = {40'd0, w_dvd[19:0], 4'd0};
                w_op_c      = w_den;
            end
            S_PUSH_X: begin w_req.op = OP_MUL; w_op_a = 64'(r_nx); w_op_b = w_pen; end
            S_PUSH_Z: begin w_req.op = OP_MUL; w_op_a = 64'(r_nz); w_op_b = w_pen; end
            S_S_X:    begin w_req.op = OP_MUL; w_op_a = 64'(r_vx); w_op_b = 64'(r_nx); end
            S_S_Z:    begin w_req.op = OP_MUL; w_op_a = 64'(r_vz); w_op_b = 64'(r_nz); end
            S_V_X:    begin w_req.op = OP_MUL; w_op_a = w_vin;     w_op_b = 64'(r_nx); end
            S_V_Z:    begin w_req.op = OP_MUL; w_op_a = w_vin;     w_op_b = 64'(r_nz); end
            default: ;
        endcase
        w_req.start = (w_req.op != OP_NOP) && !r_issued;
        w_sum  = {13'd0, r_len2} + w_res;
        w_ssum = r_s + w_sres;
        if (r_state == S_DOT_Z) begin
            w_ssum = r_dot + w_sres;
        end
        if (r_state == S_D2_Z) begin
            w_sum = r_d2 + w_res;
        end
    end

    // ---------------- wall table ----------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !s_axis_tuser && (32'(s_axis_tdata[5:0]) < WALL_DEPTH)) begin
            r_mem[w_slot] <= s_axis_tdata[101:6];
        end
        if (r_state == S_RD) begin
            r_rd <= r_mem[r_widx[AW-1:0]];
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_req.start) begin
                r_issued <= 1'b1;
            end
            if (w_done) begin
                r_issued <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_widx     <= '0;
                        r_pass     <= '0;
                        r_pass_hit <= 1'b0;
                        r_any      <= 1'b0;
                        if (!s_axis_tuser) begin
                            r_px    <= '0;
                            r_pz    <= '0;
                            r_vx    <= '0;
                            r_vz    <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_px <= w_in_px;
                            r_pz <= w_in_pz;
                            r_vx <= w_in_vx;
                            r_vz <= w_in_vz;
                            if ((r_passes == 4'd0) || (w_nwalls == '0)) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_RD;
                            end
                        end
                    end
                end
                S_RD: r_state <= S_LD;
                S_LD: begin
                    r_wx    <= 25'(w_x2) - 25'(w_x1);
                    r_wz    <= 25'(w_z2) - 25'(w_z1);
                    r_prx   <= 25'(r_px) - 25'(w_x1);
                    r_prz   <= 25'(r_pz) - 25'(w_z1);
                    r_perp  <= 1'b0;
                    r_state <= S_LEN_X;
                end
                S_LEN_X: if (w_done) begin
                    r_len2  <= w_res[50:0];
                    r_state <= S_LEN_Z;
                end
                S_LEN_Z: if (w_done) begin
                    r_len2  <= w_sum[50:0];
                    r_state <= (w_sum == '0) ? S_WEND : S_DOT_X;
                end
                S_DOT_X: if (w_done) begin
                    r_dot   <= w_sres;
                    r_state <= S_DOT_Z;
                end
                S_DOT_Z: if (w_done) begin
                    r_dot <= w_ssum;
                    priority if (w_ssum <= 64'sd0) begin
                        r_t     <= '0;
                        r_state <= S_CL_X;
                    end else if (unsigned'(w_ssum) >= {13'd0, r_len2}) begin
                        r_t     <= 25'h100_0000;
                        r_state <= S_CL_X;
                    end else begin
                        r_state <= S_T_DIV;
                    end
                end
                S_T_DIV: if (w_done) begin
                    r_t     <= w_res[24:0];
                    r_state <= S_CL_X;
                end
                S_CL_X: if (w_done) begin
                    r_dx    <= 27'(64'(r_px) - w_cx);
                    r_state <= S_CL_Z;
                end
                S_CL_Z: if (w_done) begin
                    r_dz    <= 27'(64'(r_pz) - w_cz);
                    r_state <= S_D2_X;
                end
                S_D2_X: if (w_done) begin
                    r_d2    <= w_res;
                    r_state <= S_D2_Z;
                end
                S_D2_Z: if (w_done) begin
                    r_d2    <= w_sum;
                    r_state <= (w_sum >= {40'd0, w_r2}) ? S_WEND : S_DH;
                end
                S_DH: if (w_done) begin
                    r_dh <= w_res[19:0];
                    priority if ((r_d2 > EPS2_Q) && (w_res != '0)) begin
                        r_state <= S_NX;
                    end else if ({13'd0, r_len2} <= EPS2_Q) begin
                        r_state <= S_WEND;
                    end else begin
                        r_state <= S_LH;
                    end
                end
                S_LH: if (w_done) begin
                    r_lh    <= w_res[30:0];
                    r_perp  <= 1'b1;
                    r_state <= (w_res == '0) ? S_WEND : S_NX;
                end
                S_NX: if (w_done) begin
                    r_nx    <= w_num_src[63] ? -20'(w_res) : 20'(w_res);
                    r_state <= S_NZ;
                end
                S_NZ: if (w_done) begin
                    r_nz       <= w_num_src[63] ? -20'(w_res) : 20'(w_res);
                    r_pass_hit <= 1'b1;
                    r_state    <= S_PUSH_X;
                end
                S_PUSH_X: if (w_done) begin
                    r_px    <= sat24(64'(r_px) + w_rnd24);
                    r_state <= S_PUSH_Z;
                end
                S_PUSH_Z: if (w_done) begin
                    r_pz    <= sat24(64'(r_pz) + w_rnd24);
                    r_state <= S_S_X;
                end
                S_S_X: if (w_done) begin
                    r_s     <= w_sres;
                    r_state <= S_S_Z;
                end
                S_S_Z: if (w_done) begin
                    r_s     <= w_ssum;
                    r_state <= (w_ssum < 64'sd0) ? S_V_X : S_WEND;
                end
                S_V_X: if (w_done) begin
                    r_vx    <= sat24(64'(r_vx) - w_rnd16);
                    r_state <= S_V_Z;
                end
                S_V_Z: if (w_done) begin
                    r_vz    <= sat24(64'(r_vz) - w_rnd16);
                    r_state <= S_WEND;
                end
                S_WEND: begin
                    if (r_widx + CW'(1) == w_nwalls) begin
                        // end of a pass: stop on a clean pass or at the pass limit
                        r_widx     <= '0;
                        r_pass_hit <= 1'b0;
                        r_pass     <= r_pass + 4'd1;
                        if (!r_pass_hit) begin
                            r_state <= S_DONE;
                        end else begin
                            r_any <= 1'b1;
                            if ({1'b0, r_pass} + 5'd1 == {1'b0, r_passes}) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_RD;
                            end
                        end
                    end else begin
                        r_widx  <= r_widx + CW'(1);
                        r_state <= S_RD;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out       <= {r_any, r_vz, r_vx, r_pz, r_px};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out};

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> ((r_widx < w_nwalls) && (r_pass < r_passes)))
        else $error("wall walk beyond active range");
    a_resolve_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && s_axis_tuser && (r_passes != 4'd0) && (w_nwalls != '0))
        |=> (r_state == S_RD))
        else $error("resolve did not start a wall walk");
    a_load_no_contact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !s_axis_tuser) |=> ((r_state == S_DONE) && !r_any))
        else $error("load request flagged contact");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: circle versus wall-segment collision resolver
// Loads wall tables, writes every register (extremes included) over the APB
// port, and streams load and resolve requests with bursty input and a
// stalling output. Each result is checked field by field against a given
// value or an in-bench fixed-point model of push-out and velocity clipping.
// ----------------------------------------------------------------------------
module tb;
    import csr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit FUNC_LOAD    = 1'b0;
    localparam bit FUNC_RESOLVE = 1'b1;
    localparam int DEPTH        = 64;
    localparam longint EPS2     = (64'sd1 <<< 24) / 100000000;
    localparam int CYCLE_LIMIT  = 6000000;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] pz;
        logic signed [23:0] vx;
        logic signed [23:0] vz;
        logic               hit;
    } t_res;

    typedef enum { ROW_REQ, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        t_reg_idx           reg_idx;
        logic [31:0]        value;
        bit                 func;
        logic [5:0]         slot;
        logic signed [23:0] a, b, c, d;
        bit                 typed;
        t_res               exp;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [199:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;

    circle_segment_collision_resolver_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
        .m_axis_tdata(m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // wall table and register copies
    longint wx1 [DEPTH], wz1 [DEPTH], wx2 [DEPTH], wz2 [DEPTH];
    int     walls_on;
    longint radius;
    int     passes;

    t_res   pending_q [$];
    int     mismatches = 0;
    int     n_load = 0, n_resolve = 0, n_contact = 0, n_checked = 0;
    int     burst_left = 0;
    int     cycles = 0;
    bit     hold_go = 0;
    bit     hold_done = 0;
    t_row   rows [$];

    // ---------------- fixed-point model ----------------
    function automatic longint clamp24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint m;
        longint q;
        m = (num < 0) ? -num : num;
        q = (m + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >>> 1) + b;
            end else begin
                res = res >>> 1;
            end
            b = b >>> 2;
        end
        return res;
    endfunction

    function automatic bit push_out(int i, inout longint px, inout longint pz,
                                    inout longint vx, inout longint vz);
        longint wx, wz, len2, dot, t, rem, cx, cz, dx, dz, d2, dh, lh;
        longint nx, nz, pen, s, vin;
        wx = wx2[i] - wx1[i];
        wz = wz2[i] - wz1[i];
        len2 = wx * wx + wz * wz;
        if (len2 == 0) return 0;
        dot = (px - wx1[i]) * wx + (pz - wz1[i]) * wz;
        if (dot <= 0) begin
            t = 0;
        end else if (dot >= len2) begin
            t = 64'sd1 <<< 24;
        end else begin
            rem = dot;
            t = 0;
            for (int k = 0; k < 24; k++) begin
                rem = rem <<< 1;
                t = t <<< 1;
                if (rem >= len2) begin
                    rem = rem - len2;
                    t = t | 1;
                end
            end
        end
        cx = wx1[i] + round_shift(wx * t, 24);
        cz = wz1[i] + round_shift(wz * t, 24);
        dx = px - cx;
        dz = pz - cz;
        d2 = dx * dx + dz * dz;
        if (d2 >= radius * radius) return 0;
        dh = int_sqrt(d2 <<< 16);
        if (d2 > EPS2 && dh > 0) begin
            nx = round_div(dx * (64'sd1 <<< 24), dh);
            nz = round_div(dz * (64'sd1 <<< 24), dh);
        end else begin
            // centre on the line: push along the wall normal
            if (len2 <= EPS2) return 0;
            lh = int_sqrt(len2 <<< 12);
            if (lh == 0) return 0;
            nx = round_div(-wz * (64'sd1 <<< 22), lh);
            nz = round_div(wx * (64'sd1 <<< 22), lh);
        end
        pen = (radius <<< 8) - dh;
        px = clamp24(px + round_shift(nx * pen, 24));
        pz = clamp24(pz + round_shift(nz * pen, 24));
        s = vx * nx + vz * nz;
        if (s < 0) begin
            vin = round_shift(s, 16);
            vx = clamp24(vx - round_shift(vin * nx, 16));
            vz = clamp24(vz - round_shift(vin * nz, 16));
        end
        return 1;
    endfunction

    function automatic t_res predict_collision(bit func, logic [199:0] d);
        t_res   r;
        longint px, pz, vx, vz;
        int     slot, n;
        bit     any, hit;
        r = '0;
        if (func == FUNC_LOAD) begin
            slot = d[5:0];
            wx1[slot] = $signed(d[29:6]);
            wz1[slot] = $signed(d[53:30]);
            wx2[slot] = $signed(d[77:54]);
            wz2[slot] = $signed(d[101:78]);
            return r;
        end
        px = $signed(d[125:102]);
        pz = $signed(d[149:126]);
        vx = $signed(d[173:150]);
        vz = $signed(d[197:174]);
        n = (walls_on > DEPTH) ? DEPTH : walls_on;
        any = 0;
        for (int p = 0; p < passes; p++) begin
            hit = 0;
            for (int i = 0; i < n; i++)
                if (push_out(i, px, pz, vx, vz)) hit = 1;
            if (!hit) break;
            any = 1;
        end
        r.px = px[23:0];
        r.pz = pz[23:0];
        r.vx = vx[23:0];
        r.vz = vz[23:0];
        r.hit = any;
        return r;
    endfunction

    // ---------------- drivers ----------------
    function automatic logic [199:0] pack_req(logic [5:0] slot,
            logic signed [23:0] sx, sz, ex, ez, px, pz, vx, vz);
        return {2'b00, vz, vx, pz, px, ez, ex, sz, sx, slot};
    endfunction

    task automatic send_req(bit func, logic [199:0] d, bit typed, t_res e);
        t_res pred;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                      : $urandom_range(1, 6);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= d;
        do @(posedge i_clk); while (!s_tready);
        burst_left--;
        pred = predict_collision(func, d);
        if (func == FUNC_LOAD) begin
            n_load++;
        end else begin
            n_resolve++;
        end
        pending_q.push_back(typed ? e : pred);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ACTIVE: walls_on = value[6:0];
            REG_RADIUS: radius = value[11:0];
            REG_PASSES: passes = value[3:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic add_cfg(t_reg_idx idx, logic [31:0] value);
        t_row r;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.value = value;
        rows.push_back(r);
    endtask

    task automatic add_req(bit func, logic [5:0] slot, logic signed [23:0] a, b, c, d,
                           bit typed, t_res e);
        t_row r;
        r.kind = ROW_REQ;
        r.func = func;
        r.slot = slot;
        r.a = a; r.b = b; r.c = c; r.d = d;
        r.typed = typed;
        r.exp = e;
        rows.push_back(r);
    endtask

    function automatic logic signed [23:0] rnd24();
        return 24'($urandom());
    endfunction

    function automatic logic signed [23:0] near(longint v, int span);
        return 24'(clamp24(v + $signed($urandom_range(0, 2 * span)) - span));
    endfunction

    // ---------------- result checker and output stalls ----------------
    int stall_left = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = {m_tdata[23:0], m_tdata[47:24], m_tdata[71:48], m_tdata[95:72],
                   m_tdata[96]};
            n_checked++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end else begin
                want = pending_q.pop_front();
                if (want.hit) n_contact++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: exp pos %0d,%0d vel %0d,%0d hit %0b",
                                  " | got pos %0d,%0d vel %0d,%0d hit %0b"},
                            n_checked, want.px, want.pz, want.vx, want.vz, want.hit,
                            got.px, got.pz, got.vx, got.vz, got.hit);
                end
            end
        end
        if (hold_go && !hold_done) begin
            hold_done <= 1;
            hold_left <= 600;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 25);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        t_res zero;
        int   n, w, k;
        longint f, qx, qz;
        zero = '0;
        walls_on = 0;
        radius = RADIUS_RST;
        passes = PASSES_RST;

        // after reset no walls are active: resolves echo their input
        add_req(FUNC_RESOLVE, 0, 100, -200, 5, -7, 1, '{100, -200, 5, -7, 0});
        add_req(FUNC_RESOLVE, 63, 8388607, 8388607, 8388607, 8388607, 1,
                '{8388607, 8388607, 8388607, 8388607, 0});
        add_req(FUNC_RESOLVE, 0, -8388608, -8388608, -8388608, -8388608, 1,
                '{-8388608, -8388608, -8388608, -8388608, 0});
        add_req(FUNC_LOAD, 0, -8192, 0, 8192, 0, 1, zero);
        add_req(FUNC_LOAD, 63, 8388607, -8388608, -8388608, 8388607, 1, zero);
        add_req(FUNC_LOAD, 1, 4096, 4096, 4096, 4096, 1, zero);   // zero length
        add_req(FUNC_LOAD, 2, 4096, -4096, 4096, 4096, 1, zero);
        add_cfg(REG_ACTIVE, 3);
        add_req(FUNC_RESOLVE, 0, 0, 600, 100, -300, 0, zero);
        add_req(FUNC_RESOLVE, 0, 0, 0, 50, 50, 0, zero);          // centre on wall
        add_req(FUNC_RESOLVE, 0, 9000, 100, -40, -40, 0, zero);   // beyond end
        add_req(FUNC_RESOLVE, 0, -9000, -50, 0, 900, 0, zero);    // before start
        add_req(FUNC_RESOLVE, 0, 40000, 40000, 1, 1, 0, zero);    // clear of walls
        add_req(FUNC_RESOLVE, 0, 4000, 200, 700, -700, 0, zero);  // corner
        add_cfg(REG_PASSES, 0);
        add_req(FUNC_RESOLVE, 0, 0, 600, 100, -300, 1, '{0, 600, 100, -300, 0});
        add_cfg(REG_PASSES, 15);
        add_cfg(REG_RADIUS, 4095);
        add_req(FUNC_RESOLVE, 0, 4000, 100, 8388607, -8388608, 0, zero);
        add_cfg(REG_RADIUS, 0);
        add_req(FUNC_RESOLVE, 0, 0, 10, 3, -3, 1, '{0, 10, 3, -3, 0});
        add_cfg(REG_RADIUS, 1);
        add_req(FUNC_RESOLVE, 0, 0, 0, -5, -5, 0, zero);
        add_cfg(REG_RADIUS, 1229);
        add_cfg(REG_PASSES, 4);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                drain_results();
                apb_write(rows[i].reg_idx, rows[i].value);
            end else if (rows[i].func == FUNC_LOAD) begin
                send_req(FUNC_LOAD, pack_req(rows[i].slot, rows[i].a, rows[i].b,
                         rows[i].c, rows[i].d, rnd24(), rnd24(), rnd24(), rnd24()),
                         rows[i].typed, rows[i].exp);
            end else begin
                send_req(FUNC_RESOLVE, pack_req(rows[i].slot, rnd24(), rnd24(),
                         rnd24(), rnd24(), rows[i].a, rows[i].b, rows[i].c, rows[i].d),
                         rows[i].typed, rows[i].exp);
            end
        end

        // fill the whole table; a few walls span the full range
        for (int s = 0; s < DEPTH; s++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_req(FUNC_LOAD, pack_req(6'(s), rnd24(), rnd24(), rnd24(), rnd24(),
                         rnd24(), rnd24(), rnd24(), rnd24()), 0, zero);
            end else begin
                qx = $signed($urandom_range(0, 32768)) - 16384;
                qz = $signed($urandom_range(0, 32768)) - 16384;
                send_req(FUNC_LOAD, pack_req(6'(s), 24'(qx), 24'(qz),
                         near(qx, 12000), near(qz, 12000),
                         rnd24(), rnd24(), rnd24(), rnd24()), 0, zero);
            end
        end

        for (int ph = 0; ph < 7; ph++) begin
            drain_results();
            if (ph == 5) begin
                // as many walls as the table holds or more: clamped to the depth
                apb_write(REG_ACTIVE, $urandom_range(0, 1) ? 127 : 64);
                apb_write(REG_PASSES, 1);
                n = 2;
            end else begin
                apb_write(REG_ACTIVE, $urandom_range(1, 6));
                apb_write(REG_PASSES, (ph == 3) ? 15 : $urandom_range(1, 4));
                n = 10;
            end
            k = $urandom_range(0, 3);
            apb_write(REG_RADIUS, (k == 0) ? 4095 : (k == 1) ? $urandom_range(1, 4095)
                                                  : $urandom_range(600, 3000));
            if (ph == 2) hold_go = 1;
            for (int it = 0; it < n; it++) begin
                k = $urandom_range(0, 9);
                if (k < 2 && ph != 5) begin
                    // reload a wall with a short segment near the origin
                    qx = $signed($urandom_range(0, 32768)) - 16384;
                    qz = $signed($urandom_range(0, 32768)) - 16384;
                    send_req(FUNC_LOAD, pack_req(6'($urandom_range(0, DEPTH - 1)),
                             24'(qx), 24'(qz), near(qx, 10000), near(qz, 10000),
                             rnd24(), rnd24(), rnd24(), rnd24()), 0, zero);
                end else if (k == 2) begin
                    send_req(FUNC_RESOLVE, pack_req(6'($urandom()), rnd24(), rnd24(),
                             rnd24(), rnd24(), rnd24(), rnd24(), rnd24(), rnd24()),
                             0, zero);
                end else begin
                    // a point near some active wall, moving at random
                    w = $urandom_range(0, ((walls_on > DEPTH) ? DEPTH : walls_on) - 1);
                    f = $urandom_range(0, 1024);
                    qx = wx1[w] + (((wx2[w] - wx1[w]) * f) >>> 10);
                    qz = wz1[w] + (((wz2[w] - wz1[w]) * f) >>> 10);
                    send_req(FUNC_RESOLVE, pack_req(6'($urandom()), rnd24(), rnd24(),
                             rnd24(), rnd24(), near(qx, 2000), near(qz, 2000),
                             ($urandom_range(0, 4) == 0) ? rnd24()
                                 : near(0, 20000), near(0, 20000)), 0, zero);
                end
            end
        end

        drain_results();
        repeat (50) @(posedge i_clk);
        $display("covered %0d wall loads and %0d resolves, %0d with contact",
                 n_load, n_resolve, n_contact);
        $display("registers swept through zero, one and full-scale settings");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d results differed", mismatches);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/csr_pkg.sv
rtl/core/csr_arith.sv
rtl/core/circle_segment_collision_resolver_top.sv
dv/tb.sv
